// ===== src/spt_pkg.sv =====
// Shared constants and control/status bundles for the sorted page table.
// No dependencies; imported by spt_ctrl, spt_dp and the top level.
`default_nettype none

package spt_pkg;

    // Fixed field widths of the request/result ports.
    localparam int ADDR_BITS       = 52;
    localparam int IDX_W           = 6;
    localparam int OFF_W           = 9;
    localparam int CNT_W           = 7;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_PAGE_SHIFT  = 12;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture request, open search window
        logic page_rd;     // order data valid: latch entry, fetch its page
        logic cmp;         // page data valid: compare and narrow window
        logic shift_init;  // start moving order list tail up by one
        logic shift_step;  // one read/write of the order list shift
        logic insert;      // write new entry and its order slot
        logic out_load;    // load result register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic lo_lt_hi;
        logic cmp_eq;
        logic can_insert;
        logic i_gt_lo;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/spt_ctrl.sv =====
// Sequencer for search, order-list shift and insert of the sorted page table.
// Depends on spt_pkg (t_cmd, t_sts).
`default_nettype none

module spt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire spt_pkg::t_sts i_sts,
    output spt_pkg::t_cmd      o_cmd
);
    import spt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PAGE,
        ST_CMP,
        ST_SHIFT,
        ST_INS,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.lo_lt_hi) begin
                    n_state = ST_PAGE;
                end else if (i_sts.can_insert) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = ST_SHIFT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PAGE: begin
                o_cmd.page_rd = 1'b1;
                n_state       = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.cmp_eq ? ST_DONE : ST_SEARCH;
            end
            ST_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (!i_sts.i_gt_lo) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/spt_dp.sv =====
// Datapath of the sorted page table: page store, order list, search window,
// shift pointer and result register. Depends on spt_pkg.
`default_nettype none

module spt_dp #(
    parameter int MAX_ENTRIES = spt_pkg::DEF_MAX_ENTRIES,
    parameter int PAGE_SHIFT  = spt_pkg::DEF_PAGE_SHIFT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire spt_pkg::t_cmd                 i_cmd,
    output spt_pkg::t_sts                      o_sts,
    input  wire logic                          i_req_type,
    input  wire logic [spt_pkg::ADDR_BITS-1:0] i_address,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic                               o_inserted,
    output logic                               o_full_error,
    output logic [spt_pkg::IDX_W-1:0]          o_entry_index,
    output logic [spt_pkg::OFF_W-1:0]          o_word_offset,
    output logic [spt_pkg::CNT_W-1:0]          o_entries_in_use
);
    import spt_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = ADDR_BITS - PAGE_SHIFT;
    localparam int OW = PAGE_SHIFT - 3;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    // request
    logic [PW-1:0] r_page;
    logic [OW-1:0] r_woff;
    logic          r_type;

    // search window and bookkeeping
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wa;
    logic          r_wpend;
    logic          r_hit;
    logic          r_ins;

    // memories
    logic [AW-1:0] r_ord_mem  [MAX_ENTRIES];
    logic [AW-1:0] r_ord_rd;
    logic [PW-1:0] r_page_mem [MAX_ENTRIES];
    logic [PW-1:0] r_page_rd;

    logic [CW-1:0] mid;
    logic [CW-1:0] i_dec;
    logic [AW-1:0] ord_ra;
    logic          ord_we;
    logic [AW-1:0] ord_wa;
    logic [AW-1:0] ord_wd;
    logic          full;
    logic [AW-1:0] idx_sel;
    logic [63:0]   idx_ext;
    logic [63:0]   off_ext;
    logic [63:0]   cnt_ext;

    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign i_dec = r_i - CW'(1);

    assign o_sts.lo_lt_hi   = (r_lo < r_hi);
    assign o_sts.cmp_eq     = (r_page_rd == r_page);
    assign o_sts.can_insert = r_type && (r_count < MAX_CNT);
    assign o_sts.i_gt_lo    = (r_i > r_lo);
    assign o_sts.out_free   = !o_out_valid || !i_out_stall;

    // order list: read every cycle, write on shift or insert
    assign ord_ra = i_cmd.shift_step ? i_dec[AW-1:0] : mid[AW-1:0];
    assign ord_we = (i_cmd.shift_step && r_wpend) || i_cmd.insert;
    assign ord_wa = i_cmd.insert ? r_lo[AW-1:0] : r_wa;
    assign ord_wd = i_cmd.insert ? r_count[AW-1:0] : r_ord_rd;

    always_ff @(posedge i_clk) begin
        r_ord_rd <= r_ord_mem[ord_ra];
        if (ord_we) begin
            r_ord_mem[ord_wa] <= ord_wd;
        end
    end

    // page store: addressed by the entry just read from the order list
    always_ff @(posedge i_clk) begin
        r_page_rd <= r_page_mem[r_ord_rd];
        if (i_cmd.insert) begin
            r_page_mem[r_count[AW-1:0]] <= r_page;
        end
    end

    assign full    = !r_hit && !r_ins && r_type && (r_count >= MAX_CNT);
    assign idx_sel = (r_hit || r_ins) ? r_idx : '0;
    assign idx_ext = 64'(idx_sel);
    assign off_ext = 64'(r_woff);
    assign cnt_ext = 64'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_address[ADDR_BITS-1:PAGE_SHIFT];
            r_woff <= i_address[PAGE_SHIFT-1:3];
            r_type <= i_req_type;
            r_lo   <= '0;
            r_hi   <= r_count;
            r_hit  <= 1'b0;
            r_ins  <= 1'b0;
        end
        if (i_cmd.page_rd) begin
            r_idx <= r_ord_rd;
        end
        if (i_cmd.cmp) begin
            if (r_page_rd == r_page) begin
                r_hit <= 1'b1;
            end else if (r_page_rd < r_page) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_i <= r_count;
        end
        if (i_cmd.shift_step && (r_i > r_lo)) begin
            r_wa <= r_i[AW-1:0];
            r_i  <= i_dec;
        end
        if (i_cmd.insert) begin
            r_idx <= r_count[AW-1:0];
            r_ins <= 1'b1;
        end
        if (i_cmd.out_load) begin
            o_hit            <= r_hit;
            o_inserted       <= r_ins;
            o_full_error     <= full;
            o_entry_index    <= idx_ext[IDX_W-1:0];
            o_word_offset    <= off_ext[OFF_W-1:0];
            o_entries_in_use <= cnt_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wpend     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.shift_init) begin
                r_wpend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wpend <= (r_i > r_lo);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sorted_page_table_find_or_insert.sv =====
// Top level of the sorted page table with find / find-or-insert requests.
// Depends on spt_pkg, spt_ctrl and spt_dp.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_req_type, i_address
//   result    out        o_out_valid / i_out_stall o_hit, o_inserted, o_full_error,
//                                                  o_entry_index, o_word_offset,
//                                                  o_entries_in_use
//
// One request at a time. A binary search takes up to ceil(log2(MAX_ENTRIES+1))
// probes, each an order list read, a page store read and a compare. An insert
// then moves the order list tail up one slot per cycle, one entry with a
// larger page at a time, with a final step to drain the read/write pipeline,
// and then writes the new entry. Reset (synchronous, active low) empties
// the table at once; no clearing pass. A new request is taken while a
// finished result is still stalled in the output register; the next result
// waits for it.
`default_nettype none

module sorted_page_table_find_or_insert #(
    parameter int MAX_ENTRIES = spt_pkg::DEF_MAX_ENTRIES,
    parameter int PAGE_SHIFT  = spt_pkg::DEF_PAGE_SHIFT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [spt_pkg::ADDR_BITS-1:0] i_address,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic                               o_inserted,
    output logic                               o_full_error,
    output logic [spt_pkg::IDX_W-1:0]          o_entry_index,
    output logic [spt_pkg::OFF_W-1:0]          o_word_offset,
    output logic [spt_pkg::CNT_W-1:0]          o_entries_in_use
);
    import spt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: search probes, tail shift, insert, result hand-off
    spt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, search window, result register
    spt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req_type),
        .i_address        (i_address),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_hit            (o_hit),
        .o_inserted       (o_inserted),
        .o_full_error     (o_full_error),
        .o_entry_index    (o_entry_index),
        .o_word_offset    (o_word_offset),
        .o_entries_in_use (o_entries_in_use)
    );

endmodule

`default_nettype wire
